// File: src/assert_macros.svh
// Assertion macros shared by the RTL that checks itself.
// Depends on nothing; the using module must have i_clk and i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Check a condition at every clock edge outside reset.
`define QAT_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);
// Check that a condition in one cycle implies another in the next cycle.
`define QAT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define QAT_ASSERT(lbl, expr, msg)
`define QAT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: src/qat_pkg.sv
// Shared types and constants for the quadrature azimuth tracker.
// Used by the controller, the datapath, the serial divider and the top level.
package qat_pkg;

    // Field widths.
    localparam int TPR_W      = 16;
    localparam int DEG_W      = 9;
    localparam int REM_W      = 8;
    localparam int EVT_W      = 16;
    localparam int ACT_W      = 2;
    localparam int DIV_W      = TPR_W + DEG_W;
    localparam int DIV_CNT_W  = $clog2(DIV_W + 1);
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // Action codes of an input item.
    localparam logic [ACT_W-1:0] ACT_EDGE  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_SYNC  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_HOME  = 2'd2;
    localparam logic [ACT_W-1:0] ACT_QUERY = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_REV = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PARK_AZIMUTH  = 1'd1;

    // Reset values and angle constants.
    localparam logic [TPR_W-1:0] TPR_RESET  = 16'd20700;
    localparam logic [DEG_W-1:0] PARK_RESET = 9'd0;
    localparam logic [DEG_W-1:0] DEG_FULL   = 9'd360;
    localparam logic [DEG_W-1:0] DEG_HALF   = 9'd180;

    // Division of a load product by 360: 360 is 8 times 45, and the division by 45
    // is a multiply by ceil(2^28 / 45) and a 28-bit shift, exact below 2^22.
    localparam int                 LOAD_PRE_SHIFT = 3;
    localparam int                 RECIP_W        = 23;
    localparam int                 RECIP_SHIFT    = 28;
    localparam logic [RECIP_W-1:0] RECIP_45       = 23'd5965233;

    // Which division the shared divider is working on.
    typedef enum logic [1:0] {
        DIV_MOD  = 2'd0,
        DIV_AZ   = 2'd2
    } t_div_op;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic             phase_a;
        logic             phase_b;
        logic [DEG_W-1:0] sync_azimuth;
        logic [DEG_W-1:0] target_azimuth;
    } t_in_item;

    typedef struct packed {
        logic [DEG_W-1:0] azimuth;
        logic             clockwise;
        logic [REM_W-1:0] remaining_degrees;
        logic [EVT_W-1:0] sync_events;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    capture;
        logic    div_start;
        t_div_op div_op;
        logic    upd_count;
        logic    out_load;
    } t_qat_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_load;
        logic div_last;
    } t_qat_status;

endpackage

// File: src/qat_div.sv
// Serial restoring divider, one quotient bit per cycle.
// Depends on qat_pkg for the dividend and divisor widths.
module qat_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [qat_pkg::DIV_W-1:0]  i_dividend,
    input  logic [qat_pkg::TPR_W-1:0]  i_divisor,
    output logic                       o_last,
    output logic [qat_pkg::DIV_W-1:0]  o_quotient,
    output logic [qat_pkg::TPR_W-1:0]  o_remainder
);

    logic                          r_busy;
    logic [qat_pkg::DIV_CNT_W-1:0] r_cnt;
    logic [qat_pkg::DIV_W-1:0]     r_quo;
    logic [qat_pkg::TPR_W-1:0]     r_rem;
    logic [qat_pkg::TPR_W-1:0]     n_rem;
    logic [qat_pkg::TPR_W:0]       w_shift;
    logic                          w_fit;

    // One trial subtraction of the divisor from the shifted partial remainder.
    assign w_shift = {r_rem, r_quo[qat_pkg::DIV_W-1]};
    assign w_fit   = (w_shift >= {1'b0, i_divisor});

    always_comb begin
        if (w_fit) begin
            n_rem = qat_pkg::TPR_W'(w_shift - {1'b0, i_divisor});
        end else begin
            n_rem = w_shift[qat_pkg::TPR_W-1:0];
        end
    end

    // Step counter; the divider stays busy after a start until it has produced DIV_W quotient bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= qat_pkg::DIV_CNT_W'(qat_pkg::DIV_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - qat_pkg::DIV_CNT_W'(1);
            if (r_cnt == qat_pkg::DIV_CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // The quotient shifts in from the right as the dividend shifts out.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_quo <= {r_quo[qat_pkg::DIV_W-2:0], w_fit};
            r_rem <= n_rem;
        end
    end

    assign o_last      = r_busy && (r_cnt == qat_pkg::DIV_CNT_W'(1));
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

// File: src/qat_dp.sv
// Datapath: configuration registers, tick and home counters, shared divider
// and the result register. Depends on qat_pkg and qat_div.
module qat_dp #(
    parameter int CNT_W = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [qat_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [qat_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  qat_pkg::t_in_item             i_in_item,
    input  qat_pkg::t_qat_cmd             i_cmd,
    output qat_pkg::t_qat_status          o_status,
    output qat_pkg::t_out_item            o_out_item
);

    localparam int RCP_W = qat_pkg::DIV_W - qat_pkg::LOAD_PRE_SHIFT + qat_pkg::RECIP_W;

    logic [qat_pkg::TPR_W-1:0] r_ticks_per_rev;
    logic [qat_pkg::DEG_W-1:0] r_park_azimuth;
    logic [CNT_W-1:0]          r_tick;
    logic [qat_pkg::EVT_W-1:0] r_home;
    qat_pkg::t_in_item         r_item;
    qat_pkg::t_out_item        r_out;
    logic [qat_pkg::DIV_W-1:0] r_load_prod;
    logic [qat_pkg::TPR_W:0]   r_load_quo;

    logic [qat_pkg::TPR_W-1:0] w_ring;
    logic [qat_pkg::DEG_W-1:0] w_load_deg;
    logic [RCP_W-1:0]          w_rcp_prod;
    logic [qat_pkg::DIV_W-1:0] w_dividend;
    logic [qat_pkg::TPR_W-1:0] w_divisor;
    logic                      w_last;
    logic [qat_pkg::DIV_W-1:0] w_quo;
    logic [qat_pkg::TPR_W-1:0] w_rem;
    logic [qat_pkg::TPR_W:0]   w_inc;
    logic [qat_pkg::TPR_W-1:0] w_load_pos;
    logic [qat_pkg::TPR_W-1:0] n_pos;

    logic [qat_pkg::DEG_W-1:0] w_az_raw;
    logic [qat_pkg::DEG_W-1:0] w_az;
    logic [qat_pkg::DEG_W-1:0] w_taz;
    logic [qat_pkg::DEG_W:0]   w_sum;
    logic [qat_pkg::DEG_W-1:0] w_diff;
    qat_pkg::t_out_item        n_out;

    // A zero revolution size behaves as a ring of one tick.
    assign w_ring = (r_ticks_per_rev == '0) ? qat_pkg::TPR_W'(1) : r_ticks_per_rev;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks_per_rev <= qat_pkg::TPR_RESET;
            r_park_azimuth  <= qat_pkg::PARK_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                qat_pkg::REG_TICKS_PER_REV: r_ticks_per_rev <= i_cfg_data;
                qat_pkg::REG_PARK_AZIMUTH: begin
                    r_park_azimuth <= i_cfg_data[qat_pkg::DEG_W-1:0];
                end
                default: r_ticks_per_rev <= r_ticks_per_rev;
            endcase
        end
    end

    // Tell the controller whether the incoming item loads from degrees.
    assign o_status.in_load  = (i_in_item.action == qat_pkg::ACT_SYNC) ||
                               (i_in_item.action == qat_pkg::ACT_HOME);
    assign o_status.div_last = w_last;

    // Degrees to load come from the incoming item or the park register.
    assign w_load_deg = (i_in_item.action == qat_pkg::ACT_SYNC) ?
                        i_in_item.sync_azimuth : r_park_azimuth;

    // Operand selection for the shared divider.
    always_comb begin
        case (i_cmd.div_op)
            qat_pkg::DIV_MOD: begin
                w_dividend = qat_pkg::DIV_W'(r_tick);
                w_divisor  = w_ring;
            end
            qat_pkg::DIV_AZ: begin
                w_dividend = qat_pkg::DIV_W'(r_tick) * qat_pkg::DIV_W'(qat_pkg::DEG_FULL);
                w_divisor  = w_ring;
            end
            default: begin
                w_dividend = qat_pkg::DIV_W'(r_tick);
                w_divisor  = w_ring;
            end
        endcase
    end

    qat_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.div_start),
        .i_dividend  (w_dividend),
        .i_divisor   (w_divisor),
        .o_last      (w_last),
        .o_quotient  (w_quo),
        .o_remainder (w_rem)
    );

    // Ticks for a load angle, floor(ring * deg / 360): the product is taken with the
    // item, then a shift by three and a reciprocal multiply divide it in the next cycle.
    assign w_rcp_prod = RCP_W'(r_load_prod[qat_pkg::DIV_W-1:qat_pkg::LOAD_PRE_SHIFT]) *
                        RCP_W'(qat_pkg::RECIP_45);

    always_ff @(posedge i_clk) begin
        r_load_quo <= w_rcp_prod[qat_pkg::RECIP_SHIFT +: (qat_pkg::TPR_W + 1)];
    end

    // Next tick position. A load quotient is below two revolutions, so one
    // subtraction brings it back onto the ring.
    assign w_inc = {1'b0, w_rem} + {{qat_pkg::TPR_W{1'b0}}, 1'b1};
    assign w_load_pos = (r_load_quo >= {1'b0, w_ring}) ?
                        qat_pkg::TPR_W'(r_load_quo - {1'b0, w_ring}) :
                        r_load_quo[qat_pkg::TPR_W-1:0];

    always_comb begin
        case (r_item.action)
            qat_pkg::ACT_EDGE: begin
                if (r_item.phase_a == r_item.phase_b) begin
                    n_pos = (w_rem == '0) ? (w_ring - qat_pkg::TPR_W'(1)) :
                            (w_rem - qat_pkg::TPR_W'(1));
                end else begin
                    n_pos = (w_inc >= {1'b0, w_ring}) ? '0 : w_inc[qat_pkg::TPR_W-1:0];
                end
            end
            qat_pkg::ACT_SYNC:  n_pos = w_load_pos;
            qat_pkg::ACT_HOME:  n_pos = w_load_pos;
            qat_pkg::ACT_QUERY: n_pos = w_rem;
            default:            n_pos = w_rem;
        endcase
    end

    // Tick and home counters. The tick count always stays below the ring
    // size, so it never needs more than TPR_W bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick <= '0;
            r_home <= '0;
        end else if (i_cmd.upd_count) begin
            r_tick <= n_pos[CNT_W-1:0];
            if (r_item.action == qat_pkg::ACT_HOME) begin
                r_home <= r_home + qat_pkg::EVT_W'(1);
            end
        end
    end

    // Captured item and its load product.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item      <= i_in_item;
            r_load_prod <= qat_pkg::DIV_W'(w_ring) * qat_pkg::DIV_W'(w_load_deg);
        end
    end

    // Whole-degree azimuth, clamped so that zero reads as one.
    assign w_az_raw = w_quo[qat_pkg::DEG_W-1:0];
    assign w_az     = (w_az_raw == '0) ? qat_pkg::DEG_W'(1) : w_az_raw;

    // Shortest way to the target; a target of a full turn or more wraps.
    assign w_taz = (r_item.target_azimuth >= qat_pkg::DEG_FULL) ?
                   (r_item.target_azimuth - qat_pkg::DEG_FULL) : r_item.target_azimuth;
    assign w_sum = {1'b0, w_taz} + {1'b0, qat_pkg::DEG_FULL} - {1'b0, w_az};
    assign w_diff = (w_sum >= {1'b0, qat_pkg::DEG_FULL}) ?
                    qat_pkg::DEG_W'(w_sum - {1'b0, qat_pkg::DEG_FULL}) :
                    w_sum[qat_pkg::DEG_W-1:0];

    always_comb begin
        n_out.azimuth     = w_az;
        n_out.sync_events = r_home;
        if (w_diff > qat_pkg::DEG_HALF) begin
            n_out.clockwise         = 1'b0;
            n_out.remaining_degrees = qat_pkg::REM_W'(qat_pkg::DEG_FULL - w_diff);
        end else begin
            n_out.clockwise         = 1'b1;
            n_out.remaining_degrees = w_diff[qat_pkg::REM_W-1:0];
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out <= n_out;
        end
    end

    assign o_out_item = r_out;

endmodule

// File: src/qat_ctrl.sv
// Controller state machine: input and output handshakes and the sequence of
// divisions for one item. Depends on qat_pkg.
module qat_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  qat_pkg::t_qat_status i_status,
    output qat_pkg::t_qat_cmd    o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_MOD   = 7'b0000010,
        S_LOAD  = 7'b0000100,
        S_UPD   = 7'b0001000,
        S_AZ_GO = 7'b0010000,
        S_AZ    = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_out_free;

    // The result register can take a new item when empty or being drained.
    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);

    // Next state and command decode.
    always_comb begin
        n_state          = r_state;
        o_cmd.capture    = 1'b0;
        o_cmd.div_start  = 1'b0;
        o_cmd.div_op     = qat_pkg::DIV_MOD;
        o_cmd.upd_count  = 1'b0;
        o_cmd.out_load   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    if (i_status.in_load) begin
                        n_state = S_LOAD;
                    end else begin
                        o_cmd.div_start = 1'b1;
                        n_state         = S_MOD;
                    end
                end
            end
            S_MOD: begin
                if (i_status.div_last) begin
                    n_state = S_UPD;
                end
            end
            S_LOAD: begin
                // The load quotient is registered at the end of this cycle.
                n_state = S_UPD;
            end
            S_UPD: begin
                o_cmd.upd_count = 1'b1;
                n_state         = S_AZ_GO;
            end
            S_AZ_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_op    = qat_pkg::DIV_AZ;
                n_state         = S_AZ;
            end
            S_AZ: begin
                o_cmd.div_op = qat_pkg::DIV_AZ;
                if (i_status.div_last) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                o_cmd.div_op = qat_pkg::DIV_AZ;
                if (w_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Output valid flag follows the result register.
    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// File: src/quadrature_azimuth_tracker.sv
// Quadrature azimuth tracker: one result item for every input item.
// From acceptance to result valid, an edge or query item runs two serial divisions of 25
// steps each (one quotient bit per cycle), update and restart states between, then output.
// A sync or home item gets its load position from a reciprocal multiply, not a division.
// A new item can be accepted the cycle after the result store; a stalled result delays it.
// Synchronous active-low reset restores the default configuration and clears the counters.
`include "assert_macros.svh"

module quadrature_azimuth_tracker #(
    parameter int COUNT_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  qat_pkg::t_in_item              i_in_item,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output qat_pkg::t_out_item             o_out_item,
    input  logic                           i_cfg_we,
    input  logic [qat_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [qat_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    // The tick count stays below the ring size, so it needs at most TPR_W bits.
    localparam int CNT_W = (COUNT_BITS < qat_pkg::TPR_W) ? COUNT_BITS : qat_pkg::TPR_W;

    qat_pkg::t_qat_cmd    w_cmd;
    qat_pkg::t_qat_status w_status;
    logic                 w_az_ok;
    logic                 w_rem_ok;
    logic                 w_cmd_other;

    qat_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    qat_dp #(
        .CNT_W (CNT_W)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_item   (i_in_item),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_item  (o_out_item)
    );

    // Result field checks and the commands that must not overlap a result store.
    assign w_az_ok     = (o_out_item.azimuth != '0) &&
                         (o_out_item.azimuth < qat_pkg::DEG_FULL);
    assign w_rem_ok    = (o_out_item.remaining_degrees <= qat_pkg::REM_W'(qat_pkg::DEG_HALF)) &&
                         (o_out_item.clockwise || (o_out_item.remaining_degrees != '0));
    assign w_cmd_other = w_cmd.capture || w_cmd.div_start || w_cmd.upd_count;

    // A delivered azimuth is a whole degree in one to three hundred fifty-nine.
    `QAT_ASSERT(a_az_range, !o_out_valid || w_az_ok, "azimuth out of range")

    // Remaining distance never exceeds a half turn; counterclockwise means nonzero.
    `QAT_ASSERT(a_rem_range, !o_out_valid || w_rem_ok, "bad distance")

    // Once an item is taken, the block stays busy for the next cycle.
    `QAT_ASSERT_NEXT(a_busy_after_accept, i_in_valid && o_in_ready, !o_in_ready, "ready after accept")

    // A result is stored only when no capture, division start or counter update is commanded.
    `QAT_ASSERT(a_cmd_excl, !w_cmd.out_load || !w_cmd_other, "command overlap")

endmodule
